FILE: rtl/sohm_pkg.sv
package sohm_pkg;

   localparam int BUCKETS_DEF    = 256;
   localparam int WAYS_DEF       = 4;
   localparam int SLAB_SHIFT_DEF = 12;

   localparam int KEY_W    = 64;
   localparam int CFG_W    = 9;
   localparam int COUNT_W  = 11;
   localparam int DIV_BITS = 8;   // quotient bits retired per divider cycle
   localparam logic [CFG_W-1:0] CFG_RESET = 9'd256;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_LOOKUP = 2'd1,
      CMD_REMOVE = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK   = 3'd0,
      STS_DUP  = 3'd1,
      STS_MISS = 3'd2,
      STS_FULL = 3'd3,
      STS_NULL = 3'd4
   } status_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [KEY_W-1:0]  key;
      logic [KEY_W-1:0]  value;
   } req_type;

   typedef struct packed {
      status_type          status;
      logic [KEY_W-1:0]    value_out;
      logic [COUNT_W-1:0]  entry_count;
   } rsp_type;

   typedef struct packed {
      logic              start;
      logic [KEY_W-1:0]  dividend;
      logic [CFG_W-1:0]  divisor;
   } div_req_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_READ,
      S_EXEC,
      S_OUT
   } state_type;

endpackage

FILE: rtl/slab_offset_hash_map.sv
// channel | ports                          | direction | transfer when
// req     | req_valid req_stall req_data   | in        | req_valid && !req_stall
// rsp     | rsp_valid rsp_stall rsp_data   | out       | rsp_valid && !rsp_stall
// csr     | csr_wr_en csr_wr_data          | in        | csr_wr_en
// one item passes in order through the modulo unit, the bucket hand-over, the table read,
// compare and write back, and the output register (held while a stalled result waits), then idle to accept
// the modulo unit retires 8 quotient bits a cycle over the 64-bit slab index
// after reset a clearing pass over every bucket zeroes the valid bits; req_stall is high
// a result waiting on rsp_stall does not block the next request transfer
module slab_offset_hash_map
   import sohm_pkg::*;
#(
   parameter int BUCKETS    = BUCKETS_DEF,
   parameter int WAYS       = WAYS_DEF,
   parameter int SLAB_SHIFT = SLAB_SHIFT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rsp_type           rsp_data,
   input  logic              csr_wr_en,
   input  logic [CFG_W-1:0]  csr_wr_data
);

   localparam int AW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW      = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SLOTS   = BUCKETS * WAYS;
   localparam int CNT_W   = $clog2(SLOTS + 1);
   localparam bit CLAMP   = (BUCKETS < 511);

   state_type state_ff, state_in;
   logic [CFG_W-1:0]  cfg_ff;
   logic [CFG_W-1:0]  n_eff;
   req_type           item_ff;
   logic [AW-1:0]     bucket_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   rsp_type           pend_ff, pend_in;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              load_out;
   logic              accept;
   div_req_type       div_req;
   logic              div_done;
   logic [CFG_W-1:0]  div_rem;
   logic [31:0]       rem32;
   logic [31:0]       cnt32;
   logic              clearing;
   logic              rd_en;
   logic              wr_en;
   logic [WAYS-1:0]             rd_valid, wr_valid;
   logic [WAYS-1:0][KEY_W-1:0]  rd_keys, rd_vals, wr_keys, wr_vals;
   logic [WAYS-1:0]   hit;
   logic              any_hit, any_free;
   logic [WW-1:0]     hit_way, free_way;

   always_comb begin
      n_eff = cfg_ff;
      if (cfg_ff == '0) n_eff = CFG_W'(1);
      else if (CLAMP && ({23'b0, cfg_ff} > 32'(BUCKETS))) n_eff = CFG_W'(BUCKETS);
   end

   assign accept       = req_valid && !req_stall;
   assign req_stall    = (state_ff != S_IDLE) || clearing;
   assign div_req.start    = accept;
   assign div_req.dividend = req_data.key >> SLAB_SHIFT;
   assign div_req.divisor  = n_eff;
   assign rem32 = 32'(div_rem);
   assign rd_en = (state_ff == S_READ);

   sohm_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .done      (div_done),
      .remainder (div_rem)
   );

   sohm_slot_mem #(.BUCKETS(BUCKETS), .WAYS(WAYS), .AW(AW)) u_mem (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_addr  (bucket_ff),
      .wr_en    (wr_en),
      .wr_addr  (bucket_ff),
      .wr_valid (wr_valid),
      .wr_keys  (wr_keys),
      .wr_vals  (wr_vals),
      .rd_valid (rd_valid),
      .rd_keys  (rd_keys),
      .rd_vals  (rd_vals),
      .clearing (clearing)
   );

   // way match and lowest free way
   always_comb begin
      hit      = '0;
      any_hit  = 1'b0;
      any_free = 1'b0;
      hit_way  = '0;
      free_way = '0;
      for (int w = 0; w < WAYS; w++)
         hit[w] = rd_valid[w] && (rd_keys[w] == item_ff.key);
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit[w]) begin
            any_hit = 1'b1;
            hit_way = WW'(w);
         end
         if (!rd_valid[w]) begin
            any_free = 1'b1;
            free_way = WW'(w);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      pend_in      = pend_ff;
      wr_en        = 1'b0;
      wr_valid     = rd_valid;
      wr_keys      = rd_keys;
      wr_vals      = rd_vals;
      load_out     = 1'b0;
      cnt32        = 32'(cnt_ff);
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_DIV;
         S_DIV:  if (div_done) state_in = S_READ;
         S_READ: state_in = S_EXEC;
         S_EXEC: begin
            pend_in.status    = STS_OK;
            pend_in.value_out = '0;
            unique case (item_ff.cmd)
               CMD_INSERT: begin
                  if (item_ff.value == '0) pend_in.status = STS_NULL;
                  else if (any_hit) pend_in.status = STS_DUP;
                  else if (!any_free) pend_in.status = STS_FULL;
                  else begin
                     wr_en              = 1'b1;
                     wr_valid[free_way] = 1'b1;
                     wr_keys[free_way]  = item_ff.key;
                     wr_vals[free_way]  = item_ff.value;
                     cnt_in             = cnt_ff + CNT_W'(1);
                  end
               end
               CMD_LOOKUP: begin
                  if (any_hit) pend_in.value_out = rd_vals[hit_way];
                  else pend_in.status = STS_MISS;
               end
               CMD_REMOVE: begin
                  if (any_hit) begin
                     pend_in.value_out = rd_vals[hit_way];
                     wr_en             = 1'b1;
                     wr_valid[hit_way] = 1'b0;
                     if (cnt_ff != '0) cnt_in = cnt_ff - CNT_W'(1);
                  end else begin
                     pend_in.status = STS_MISS;
                  end
               end
               CMD_NONE: ;
               default: ;
            endcase
            cnt32 = 32'(cnt_in);
            pend_in.entry_count = cnt32[COUNT_W-1:0];
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               load_out = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (load_out) rsp_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cfg_ff       <= CFG_RESET;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) cfg_ff <= csr_wr_data;
      end
      if (accept) item_ff <= req_data;
      if (div_done) bucket_ff <= rem32[AW-1:0];
      pend_ff <= pend_in;
      if (load_out) rsp_ff <= pend_ff;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      {1'b0, cnt_ff} <= (CNT_W + 1)'(SLOTS))
      else $error("entry count above slot total");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("modulo result outside divide state");

   a_insert_counts: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EXEC && item_ff.cmd == CMD_INSERT && wr_en)
      |=> cnt_ff == $past(cnt_ff) + CNT_W'(1))
      else $error("insert did not bump entry count");

   a_write_only_exec: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> state_ff == S_EXEC)
      else $error("table write outside execute state");

endmodule

FILE: rtl/sohm_divider.sv
module sohm_divider
   import sohm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       div_req,
   output logic              done,
   output logic [CFG_W-1:0]  remainder
);

   localparam int STEPS = KEY_W / DIV_BITS;
   localparam int STEP_W = $clog2(STEPS + 1);

   logic [KEY_W-1:0]   quo_ff, quo_in;
   logic [CFG_W-1:0]   rem_ff, rem_in;
   logic [CFG_W-1:0]   dvs_ff, dvs_in;
   logic [STEP_W-1:0]  cnt_ff, cnt_in;
   logic               busy_ff, busy_in;
   logic               done_ff, done_in;
   logic [CFG_W:0]     r;
   logic [KEY_W-1:0]   q;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r       = {1'b0, rem_ff};
      q       = quo_ff;
      if (div_req.start) begin
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dvs_in  = div_req.divisor;
         cnt_in  = STEP_W'(STEPS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // restoring division, several quotient bits per cycle
         for (int i = 0; i < DIV_BITS; i++) begin
            r = {r[CFG_W-1:0], q[KEY_W-1]};
            q = {q[KEY_W-2:0], 1'b0};
            if (r >= {1'b0, dvs_ff}) r = r - {1'b0, dvs_ff};
         end
         quo_in = q;
         rem_in = r[CFG_W-1:0];
         cnt_in = cnt_ff - STEP_W'(1);
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < dvs_ff)
      else $error("remainder not below divisor");

   a_done_ends_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while still busy");

endmodule

FILE: rtl/sohm_slot_mem.sv
module sohm_slot_mem
   import sohm_pkg::*;
#(
   parameter int BUCKETS = BUCKETS_DEF,
   parameter int WAYS    = WAYS_DEF,
   parameter int AW      = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [AW-1:0]               rd_addr,
   input  logic                        wr_en,
   input  logic [AW-1:0]               wr_addr,
   input  logic [WAYS-1:0]             wr_valid,
   input  logic [WAYS-1:0][KEY_W-1:0]  wr_keys,
   input  logic [WAYS-1:0][KEY_W-1:0]  wr_vals,
   output logic [WAYS-1:0]             rd_valid,
   output logic [WAYS-1:0][KEY_W-1:0]  rd_keys,
   output logic [WAYS-1:0][KEY_W-1:0]  rd_vals,
   output logic                        clearing
);

   localparam int ROW_W = WAYS * (2 * KEY_W + 1);

   logic [ROW_W-1:0] slot_mem_ff [BUCKETS];
   logic [ROW_W-1:0] rd_row_ff;
   logic [ROW_W-1:0] wd;
   logic [AW-1:0]    wa;
   logic             we;
   logic [AW-1:0]    clr_addr_ff, clr_addr_in;
   logic             clr_busy_ff, clr_busy_in;

   always_comb begin
      clr_addr_in = clr_addr_ff;
      clr_busy_in = clr_busy_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (clr_addr_ff == AW'(BUCKETS - 1)) clr_busy_in = 1'b0;
      end
      we = clr_busy_ff || wr_en;
      wa = clr_busy_ff ? clr_addr_ff : wr_addr;
      wd = clr_busy_ff ? '0 : {wr_vals, wr_keys, wr_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff <= '0;
         clr_busy_ff <= 1'b1;
      end else begin
         clr_addr_ff <= clr_addr_in;
         clr_busy_ff <= clr_busy_in;
      end
   end

   always_ff @(posedge clock) begin
      if (we) slot_mem_ff[wa] <= wd;
      if (rd_en) rd_row_ff <= slot_mem_ff[rd_addr];
   end

   assign {rd_vals, rd_keys, rd_valid} = rd_row_ff;
   assign clearing = clr_busy_ff;

   a_no_write_in_clear: assert property (@(posedge clock) disable iff (reset)
      clr_busy_ff |-> !wr_en && !rd_en)
      else $error("table access during clearing pass");

endmodule

FILE: bench/slab_offset_hash_map_test.sv
`timescale 1ns / 1ps

class map_scoreboard;
   localparam int NB = 256;
   localparam int NW = 4;
   logic [63:0] keys [NB*NW];
   logic [63:0] handles [NB*NW];
   bit          used [NB*NW];
   int unsigned stored;
   logic [8:0]  buckets_cfg;
   sohm_pkg::rsp_type pending [$];
   int errors;

   function new();
      for (int i = 0; i < NB*NW; i++) begin
         used[i] = 0;
         keys[i] = '0;
         handles[i] = '0;
      end
      stored = 0;
      buckets_cfg = 9'd256;
      errors = 0;
   endfunction

   function int unsigned bucket_of(logic [63:0] key);
      logic [63:0] n;
      n = buckets_cfg;
      if (n == 0) n = 1;
      if (n > NB) n = NB;
      return int'((key >> 12) % n);
   endfunction

   function void note_request(sohm_pkg::req_type r);
      sohm_pkg::rsp_type e;
      int unsigned b;
      int hit;
      int slot_free;
      b = bucket_of(r.key);
      hit = -1;
      slot_free = -1;
      for (int w = 0; w < NW; w++) begin
         if (used[b*NW+w] && keys[b*NW+w] == r.key && hit < 0) hit = b*NW+w;
         if (!used[b*NW+w] && slot_free < 0) slot_free = b*NW+w;
      end
      e.status = sohm_pkg::STS_OK;
      e.value_out = '0;
      case (r.cmd)
         sohm_pkg::CMD_INSERT: begin
            if (r.value == 0) e.status = sohm_pkg::STS_NULL;
            else if (hit >= 0) e.status = sohm_pkg::STS_DUP;
            else if (slot_free < 0) e.status = sohm_pkg::STS_FULL;
            else begin
               keys[slot_free] = r.key;
               handles[slot_free] = r.value;
               used[slot_free] = 1;
               stored++;
            end
         end
         sohm_pkg::CMD_LOOKUP: begin
            if (hit >= 0) e.value_out = handles[hit];
            else e.status = sohm_pkg::STS_MISS;
         end
         sohm_pkg::CMD_REMOVE: begin
            if (hit >= 0) begin
               e.value_out = handles[hit];
               used[hit] = 0;
               if (stored > 0) stored--;
            end else e.status = sohm_pkg::STS_MISS;
         end
         default: ;
      endcase
      e.entry_count = stored[10:0];
      pending.push_back(e);
   endfunction

   function void check_response(sohm_pkg::rsp_type a);
      sohm_pkg::rsp_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected response %h", $realtime, a);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (a.status !== e.status) begin
         $display("%0t: status expected %0d actual %0d", $realtime, e.status, a.status);
         errors++;
      end
      if (a.value_out !== e.value_out) begin
         $display("%0t: value_out expected %h actual %h", $realtime, e.value_out,
                  a.value_out);
         errors++;
      end
      if (a.entry_count !== e.entry_count) begin
         $display("%0t: entry_count expected %0d actual %0d", $realtime,
                  e.entry_count, a.entry_count);
         errors++;
      end
   endfunction
endclass

module slab_offset_hash_map_test;
   import sohm_pkg::*;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_stall;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 0;
   logic [8:0]  csr_wr_data = '0;

   map_scoreboard board;
   bit          calm = 0;
   bit          hold_rsp = 0;
   int          cycles = 0;
   logic [63:0] key_pool [16];

   slab_offset_hash_map uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 400000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // response side: check on transfer, random stall bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_response(rsp_data);
   end

   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_rsp) rsp_stall <= 1;
         else if (!calm && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 10);
            rsp_stall <= 1;
            repeat (n) @(negedge clock);
            rsp_stall <= 0;
         end else rsp_stall <= 0;
      end
   end

   task automatic send(req_type r);
      req_valid <= 1;
      req_data <= r;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      board.note_request(r);
      @(negedge clock);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
   endtask

   task automatic send_op(cmd_type c, logic [63:0] k, logic [63:0] v);
      req_type r;
      r.cmd = c;
      r.key = k;
      r.value = v;
      send(r);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic set_buckets(logic [8:0] n);
      drain();
      csr_wr_en <= 1;
      csr_wr_data <= n;
      @(negedge clock);
      csr_wr_en <= 0;
      board.buckets_cfg = n;
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic random_phase(int count);
      cmd_type c;
      logic [63:0] k;
      logic [63:0] v;
      for (int i = 0; i < count; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: c = CMD_INSERT;
            4, 5, 6: c = CMD_LOOKUP;
            7, 8: c = CMD_REMOVE;
            default: c = CMD_NONE;
         endcase
         if ($urandom_range(0, 7) == 0) k = rand64();
         else k = key_pool[$urandom_range(0, 15)];
         v = ($urandom_range(0, 15) == 0) ? 64'd0 : rand64();
         send_op(c, k, v);
      end
   endtask

   initial begin
      board = new();
      for (int i = 0; i < 16; i++) key_pool[i] = rand64();
      repeat (5) @(negedge clock);
      reset <= 0;

      // directed: extremes, every command, null, dup, full, unused command
      send_op(CMD_INSERT, 64'd0, 64'd0);
      send_op(CMD_INSERT, 64'd0, '1);
      send_op(CMD_INSERT, 64'd0, 64'd5);
      send_op(CMD_LOOKUP, 64'd0, 64'd0);
      send_op(CMD_INSERT, '1, 64'h8000_0000_0000_0001);
      send_op(CMD_LOOKUP, '1, '1);
      send_op(CMD_NONE, '1, '1);
      send_op(CMD_REMOVE, '1, 64'd0);
      send_op(CMD_REMOVE, '1, 64'd0);
      send_op(CMD_LOOKUP, 64'h1234, 64'd0);
      // five keys in bucket 0 overflow its four ways
      for (int i = 1; i <= 5; i++) send_op(CMD_INSERT, 64'(i) << 20, 64'(i));
      send_op(CMD_LOOKUP, 64'd2 << 20, 64'd0);

      // long receiver hold-off so the block backs up
      hold_rsp = 1;
      fork
         begin
            repeat (60) @(negedge clock);
            hold_rsp = 0;
         end
         random_phase(10);
      join
      drain();

      random_phase(300);
      set_buckets(9'd0);
      random_phase(300);
      set_buckets(9'd1);
      random_phase(250);
      set_buckets(9'd300);
      random_phase(250);
      set_buckets(9'd7);
      random_phase(250);
      set_buckets(9'd256);
      random_phase(300);
      calm = 1;
      random_phase(200);
      req_valid <= 0;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

FILE: files.f
rtl/sohm_pkg.sv
rtl/sohm_divider.sv
rtl/sohm_slot_mem.sv
rtl/slab_offset_hash_map.sv
bench/slab_offset_hash_map_test.sv
